FILE: src/hmd_pkg.sv
// Shared types and constants of the hinge mode detector.
// Holds the mode codes, configuration register indexes and the configuration struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hmd_pkg;

    localparam int ANGLE_W  = 13;
    localparam int ORIENT_W = 3;
    localparam int MODE_W   = 3;
    localparam int LIMIT_W  = 12;
    localparam int HYST_W   = 10;
    localparam int COUNT_W  = 4;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 12;
    localparam int CALC_W   = 15;

    localparam logic [MODE_W-1:0] MODE_CLOSING = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LAPTOP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLAT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TENT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TABLET  = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_CLOSING_LIMIT     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LAPTOP_LIMIT      = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FLAT_LIMIT        = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TENT_LIMIT        = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_HYSTERESIS_BAND   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_STABILITY_SAMPLES = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_FREEZE_LENGTH     = 3'd6;

    localparam logic [LIMIT_W-1:0] RST_CLOSING_LIMIT     = 12'd450;
    localparam logic [LIMIT_W-1:0] RST_LAPTOP_LIMIT      = 12'd1450;
    localparam logic [LIMIT_W-1:0] RST_FLAT_LIMIT        = 12'd2250;
    localparam logic [LIMIT_W-1:0] RST_TENT_LIMIT        = 12'd3300;
    localparam logic [HYST_W-1:0]  RST_HYSTERESIS_BAND   = 10'd150;
    localparam logic [COUNT_W-1:0] RST_STABILITY_SAMPLES = 4'd4;
    localparam logic [COUNT_W-1:0] RST_FREEZE_LENGTH     = 4'd6;

    localparam logic signed [ANGLE_W-1:0] MIRROR_BELOW = 13'sd900;
    localparam logic signed [CALC_W-1:0]  FULL_TURN    = 15'sd3600;
    localparam logic [COUNT_W-1:0]        COUNT_MAX    = 4'd15;

    typedef struct packed {
        logic [LIMIT_W-1:0] closing_limit;
        logic [LIMIT_W-1:0] laptop_limit;
        logic [LIMIT_W-1:0] flat_limit;
        logic [LIMIT_W-1:0] tent_limit;
        logic [HYST_W-1:0]  hysteresis_band;
        logic [COUNT_W-1:0] stability_samples;
        logic [COUNT_W-1:0] freeze_length;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] device_mode;
        logic              tablet_like;
        logic              frozen;
    } result_t;

endpackage

`default_nettype wire

FILE: src/hinge_mode_detector.sv
// Top level of the hinge mode detector.
// Input register, mode tracker and output register; depends on hmd_pkg, hmd_cfg, hmd_tracker.
`default_nettype none

// The block takes one hinge-angle sample per request and returns one mode result per
// sample, in order. It sustains one sample per clock cycle while the output is not
// stalled by m_tready: a sample passes through the input register and then the output
// register, and the only loop is the update of the mode state. Configuration writes are
// always taken and must be issued while no sample is in flight.
module hinge_mode_detector (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [hmd_pkg::CIDX_W-1:0]  cfg_index,
    input  wire  [hmd_pkg::CDATA_W-1:0] cfg_data,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [15:0]                 s_tdata,   // hinge_angle[12:0], orientation_code[15:13]
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [7:0]                  m_tdata    // device_mode[2:0], tablet_like[3], frozen[4]
);
    import hmd_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic                       in_valid_reg,  in_valid_next;
    logic signed [ANGLE_W-1:0]  in_angle_reg,  in_angle_next;
    logic [ORIENT_W-1:0]        in_orient_reg, in_orient_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_data_reg,  out_data_next;
    logic                       advance;
    logic                       step;

    hmd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hmd_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .angle  (in_angle_reg),
        .orient (in_orient_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        advance  = !out_valid_reg || m_tready;
        step     = in_valid_reg && advance;
        s_tready = !in_valid_reg || advance;

        in_valid_next  = in_valid_reg;
        in_angle_next  = in_angle_reg;
        in_orient_next = in_orient_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            if (s_tvalid)
            begin
                in_angle_next  = $signed(s_tdata[ANGLE_W-1:0]);
                in_orient_next = s_tdata[ANGLE_W+ORIENT_W-1:ANGLE_W];
            end
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
            out_valid_next = in_valid_reg;
        if (step)
            out_data_next = result;

        m_tvalid = out_valid_reg;
        m_tdata  = {3'b000, out_data_reg.frozen, out_data_reg.tablet_like,
                    out_data_reg.device_mode};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_angle_reg  <= in_angle_next;
        in_orient_reg <= in_orient_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: src/hmd_cfg.sv
// Configuration register file of the hinge mode detector.
// Takes register writes from the configuration channel; depends on hmd_pkg.
`default_nettype none

module hmd_cfg (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [hmd_pkg::CIDX_W-1:0]  cfg_index,
    input  wire  [hmd_pkg::CDATA_W-1:0] cfg_data,
    output hmd_pkg::cfg_t               cfg
);
    import hmd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CLOSING_LIMIT:     cfg_next.closing_limit     = cfg_data[LIMIT_W-1:0];
                CFG_LAPTOP_LIMIT:      cfg_next.laptop_limit      = cfg_data[LIMIT_W-1:0];
                CFG_FLAT_LIMIT:        cfg_next.flat_limit        = cfg_data[LIMIT_W-1:0];
                CFG_TENT_LIMIT:        cfg_next.tent_limit        = cfg_data[LIMIT_W-1:0];
                CFG_HYSTERESIS_BAND:   cfg_next.hysteresis_band   = cfg_data[HYST_W-1:0];
                CFG_STABILITY_SAMPLES: cfg_next.stability_samples = cfg_data[COUNT_W-1:0];
                CFG_FREEZE_LENGTH:     cfg_next.freeze_length     = cfg_data[COUNT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.closing_limit     <= RST_CLOSING_LIMIT;
            cfg_reg.laptop_limit      <= RST_LAPTOP_LIMIT;
            cfg_reg.flat_limit        <= RST_FLAT_LIMIT;
            cfg_reg.tent_limit        <= RST_TENT_LIMIT;
            cfg_reg.hysteresis_band   <= RST_HYSTERESIS_BAND;
            cfg_reg.stability_samples <= RST_STABILITY_SAMPLES;
            cfg_reg.freeze_length     <= RST_FREEZE_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hmd_propose.sv
// Threshold comparator that proposes a mode from one angle and the current stable mode.
// Pure combinational logic; depends on hmd_pkg.
`default_nettype none

module hmd_propose (
    input  wire signed [hmd_pkg::ANGLE_W-1:0] angle,
    input  wire        [hmd_pkg::MODE_W-1:0]  cur_mode,
    input  hmd_pkg::cfg_t                     cfg,
    output logic       [hmd_pkg::MODE_W-1:0]  proposed
);
    import hmd_pkg::*;

    logic signed [CALC_W-1:0] a_ext;
    logic signed [CALC_W-1:0] a;
    logic signed [CALC_W-1:0] c;
    logic signed [CALC_W-1:0] l;
    logic signed [CALC_W-1:0] f;
    logic signed [CALC_W-1:0] t;
    logic signed [CALC_W-1:0] h;

    always_comb
    begin
        a_ext = CALC_W'(angle);
        c = $signed({3'b000, cfg.closing_limit});
        l = $signed({3'b000, cfg.laptop_limit});
        f = $signed({3'b000, cfg.flat_limit});
        t = $signed({3'b000, cfg.tent_limit});
        h = $signed({5'b00000, cfg.hysteresis_band});

        // Below 90 degrees in tablet mode the hinge has wrapped past a full turn.
        if (cur_mode == MODE_TABLET && angle < MIRROR_BELOW)
            a = FULL_TURN - a_ext;
        else
            a = a_ext;

        if (angle < 0)
        begin
            proposed = MODE_LAPTOP;
        end
        else
        begin
            case (cur_mode)
                MODE_CLOSING:
                begin
                    proposed = (a >= c + h) ? MODE_LAPTOP : MODE_CLOSING;
                end
                MODE_LAPTOP:
                begin
                    if (a < c)
                        proposed = MODE_CLOSING;
                    else if (a >= l + h)
                        proposed = MODE_FLAT;
                    else
                        proposed = MODE_LAPTOP;
                end
                MODE_FLAT:
                begin
                    if (a < c)
                        proposed = MODE_CLOSING;
                    else if (a < l - h)
                        proposed = MODE_LAPTOP;
                    else if (a >= f + h)
                        proposed = MODE_TENT;
                    else
                        proposed = MODE_FLAT;
                end
                MODE_TENT:
                begin
                    if (a < c)
                        proposed = MODE_CLOSING;
                    else if (a < f - h)
                        proposed = MODE_FLAT;
                    else if (a >= t + h)
                        proposed = MODE_TABLET;
                    else
                        proposed = MODE_TENT;
                end
                default:
                begin
                    proposed = (a < t - h) ? MODE_TENT : MODE_TABLET;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/hmd_tracker.sv
// Mode state of the hinge mode detector: orientation freeze, candidate and stable mode.
// Updates its state on each processed sample; depends on hmd_pkg and hmd_propose.
`default_nettype none

module hmd_tracker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                step,
    input  wire signed [hmd_pkg::ANGLE_W-1:0]  angle,
    input  wire        [hmd_pkg::ORIENT_W-1:0] orient,
    input  hmd_pkg::cfg_t                      cfg,
    output hmd_pkg::result_t                   result
);
    import hmd_pkg::*;

    logic [MODE_W-1:0]   stable_mode_reg,     stable_mode_next;
    logic                orient_seen_reg,     orient_seen_next;
    logic [ORIENT_W-1:0] last_orient_reg,     last_orient_next;
    logic [COUNT_W-1:0]  freeze_left_reg,     freeze_left_next;
    logic                cand_valid_reg,      cand_valid_next;
    logic [MODE_W-1:0]   cand_reg,            cand_next;
    logic [COUNT_W-1:0]  agree_count_reg,     agree_count_next;

    logic [MODE_W-1:0]   proposed;
    logic [MODE_W-1:0]   next_mode;
    logic [COUNT_W-1:0]  freeze_eff;
    logic [COUNT_W-1:0]  agree_inc;
    logic                orient_change;
    logic                neighbor;
    logic                frozen;

    hmd_propose u_propose (
        .angle    (angle),
        .cur_mode (stable_mode_reg),
        .cfg      (cfg),
        .proposed (proposed)
    );

    always_comb
    begin
        orient_change    = orient_seen_reg && (orient != last_orient_reg);
        freeze_eff       = orient_change ? cfg.freeze_length : freeze_left_reg;

        stable_mode_next = stable_mode_reg;
        orient_seen_next = orient_seen_reg;
        last_orient_next = last_orient_reg;
        freeze_left_next = freeze_left_reg;
        cand_valid_next  = cand_valid_reg;
        cand_next        = cand_reg;
        agree_count_next = agree_count_reg;
        frozen           = 1'b0;

        // A tent-to-tablet move in progress keeps counting once the hinge wraps past a full turn.
        if (stable_mode_reg == MODE_TENT && cand_valid_reg && cand_reg == MODE_TABLET &&
            angle < MIRROR_BELOW && agree_count_reg != '0)
            next_mode = MODE_TABLET;
        else
            next_mode = proposed;

        neighbor  = ({1'b0, next_mode} == {1'b0, stable_mode_reg} + 4'd1) ||
                    ({1'b0, next_mode} + 4'd1 == {1'b0, stable_mode_reg});
        agree_inc = (agree_count_reg < COUNT_MAX) ? agree_count_reg + 4'd1 : agree_count_reg;

        if (step)
        begin
            orient_seen_next = 1'b1;
            last_orient_next = orient;
            if (freeze_eff != '0)
            begin
                freeze_left_next = freeze_eff - 4'd1;
                cand_valid_next  = 1'b0;
                cand_next        = MODE_CLOSING;
                agree_count_next = '0;
                frozen           = 1'b1;
            end
            else
            begin
                freeze_left_next = freeze_eff;
                if (next_mode == stable_mode_reg || !neighbor)
                begin
                    cand_valid_next  = 1'b0;
                    cand_next        = MODE_CLOSING;
                    agree_count_next = '0;
                end
                else if (!cand_valid_reg || cand_reg != next_mode)
                begin
                    cand_valid_next  = 1'b1;
                    cand_next        = next_mode;
                    agree_count_next = 4'd1;
                end
                else if (agree_inc >= cfg.stability_samples)
                begin
                    stable_mode_next = next_mode;
                    cand_valid_next  = 1'b0;
                    cand_next        = MODE_CLOSING;
                    agree_count_next = '0;
                end
                else
                begin
                    agree_count_next = agree_inc;
                end
            end
        end

        result.device_mode = stable_mode_next;
        result.tablet_like = (stable_mode_next == MODE_TENT) || (stable_mode_next == MODE_TABLET);
        result.frozen      = frozen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_mode_reg <= MODE_LAPTOP;
            orient_seen_reg <= 1'b0;
            last_orient_reg <= '0;
            freeze_left_reg <= '0;
            cand_valid_reg  <= 1'b0;
            cand_reg        <= MODE_CLOSING;
            agree_count_reg <= '0;
        end
        else
        begin
            stable_mode_reg <= stable_mode_next;
            orient_seen_reg <= orient_seen_next;
            last_orient_reg <= last_orient_next;
            freeze_left_reg <= freeze_left_next;
            cand_valid_reg  <= cand_valid_next;
            cand_reg        <= cand_next;
            agree_count_reg <= agree_count_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_holds_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(stable_mode_reg))
        else $error("Stable mode changed without a sample.");

    a_frozen_holds_mode: assert property (@(posedge clk) disable iff (!rst_n)
        step && frozen |=> $stable(stable_mode_reg) && !cand_valid_reg)
        else $error("Mode or candidate moved during a freeze.");

    a_neighbor_only: assert property (@(posedge clk) disable iff (!rst_n)
        step && stable_mode_next != stable_mode_reg |-> neighbor && cand_valid_reg)
        else $error("Stable mode jumped to a mode that is not a neighbor.");

    a_no_count_without_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        !cand_valid_reg |-> agree_count_reg == '0)
        else $error("Agreement count is nonzero without a candidate.");
`endif

endmodule

`default_nettype wire

FILE: tb/hinge_mode_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of hinge_mode_detector: directed samples, then random sample runs.
// Predicts or looks up every mode result and checks it in order; depends on hmd_pkg and the block.

module hinge_mode_detector_tb;
    import hmd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        int      angle;
        logic [ORIENT_W-1:0] ori;
        bit      fixed;
        result_t want;
    } probe_t;

    localparam result_t NO_RESULT   = '0;
    localparam result_t LAPTOP_OPEN = '{MODE_LAPTOP, 1'b0, 1'b0};
    localparam result_t LAPTOP_HELD = '{MODE_LAPTOP, 1'b0, 1'b1};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;

    cfg_t                thresholds = '{RST_CLOSING_LIMIT, RST_LAPTOP_LIMIT, RST_FLAT_LIMIT,
                                        RST_TENT_LIMIT, RST_HYSTERESIS_BAND,
                                        RST_STABILITY_SAMPLES, RST_FREEZE_LENGTH};
    logic [MODE_W-1:0]   mode_now = MODE_LAPTOP;
    bit                  orient_known = 1'b0;
    logic [ORIENT_W-1:0] orient_last = '0;
    logic [COUNT_W-1:0]  hold_left = '0;
    bit                  pend_valid = 1'b0;
    logic [MODE_W-1:0]   pend_mode = MODE_CLOSING;
    logic [COUNT_W-1:0]  pend_count = '0;

    result_t             modes_due [$];
    int                  mismatches = 0;
    int                  cycles = 0;
    int                  stall_left = 0;
    bit                  gaps_on = 1'b1;

    logic [CIDX_W-1:0]   reg_slot [7] = '{CFG_CLOSING_LIMIT, CFG_LAPTOP_LIMIT, CFG_FLAT_LIMIT,
                                          CFG_TENT_LIMIT, CFG_HYSTERESIS_BAND,
                                          CFG_STABILITY_SAMPLES, CFG_FREEZE_LENGTH};

    // Climb from laptop to tablet, with a freeze, a non-neighbor jump and the tent wrap.
    probe_t probes [25] = '{
        '{1000,  3'd0, 1'b1, LAPTOP_OPEN},
        '{-3600, 3'd0, 1'b1, LAPTOP_OPEN},
        '{3600,  3'd0, 1'b0, NO_RESULT},
        '{3000,  3'd5, 1'b1, LAPTOP_HELD},
        '{0,     3'd5, 1'b1, LAPTOP_HELD},
        '{200,   3'd5, 1'b1, LAPTOP_HELD},
        '{-100,  3'd5, 1'b1, LAPTOP_HELD},
        '{1800,  3'd5, 1'b1, LAPTOP_HELD},
        '{3600,  3'd5, 1'b1, LAPTOP_HELD},
        '{2000,  3'd5, 1'b0, NO_RESULT},
        '{2000,  3'd5, 1'b0, NO_RESULT},
        '{2000,  3'd5, 1'b0, NO_RESULT},
        '{2000,  3'd5, 1'b0, NO_RESULT},
        '{3000,  3'd5, 1'b0, NO_RESULT},
        '{3000,  3'd5, 1'b0, NO_RESULT},
        '{3000,  3'd5, 1'b0, NO_RESULT},
        '{3000,  3'd5, 1'b0, NO_RESULT},
        '{100,   3'd5, 1'b0, NO_RESULT},
        '{3500,  3'd5, 1'b0, NO_RESULT},
        '{100,   3'd5, 1'b0, NO_RESULT},
        '{100,   3'd5, 1'b0, NO_RESULT},
        '{100,   3'd5, 1'b0, NO_RESULT},
        '{100,   3'd5, 1'b0, NO_RESULT},
        '{3100,  3'd5, 1'b0, NO_RESULT},
        '{-50,   3'd5, 1'b0, NO_RESULT}
    };

    hinge_mode_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void drop_candidate();
        pend_valid = 1'b0;
        pend_mode  = MODE_CLOSING;
        pend_count = '0;
    endfunction

    function automatic result_t track_mode(input logic signed [ANGLE_W-1:0] angle,
                                           input logic [ORIENT_W-1:0] ori);
        int                a;
        int                c;
        int                l;
        int                f;
        int                t;
        int                h;
        logic [MODE_W-1:0] nxt;
        result_t           res;
        a = angle;
        c = int'(thresholds.closing_limit);
        l = int'(thresholds.laptop_limit);
        f = int'(thresholds.flat_limit);
        t = int'(thresholds.tent_limit);
        h = int'(thresholds.hysteresis_band);
        res.frozen = 1'b0;
        if (orient_known && ori != orient_last)
        begin
            hold_left   = thresholds.freeze_length;
            orient_last = ori;
        end
        else if (!orient_known)
        begin
            orient_known = 1'b1;
            orient_last  = ori;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            drop_candidate();
            res.frozen = 1'b1;
        end
        else
        begin
            if (a < 0)
                nxt = MODE_LAPTOP;
            else
            begin
                if (mode_now == MODE_TABLET && a < MIRROR_BELOW)
                    a = FULL_TURN - a;
                case (mode_now)
                    MODE_CLOSING:
                        nxt = (a >= c + h) ? MODE_LAPTOP : MODE_CLOSING;
                    MODE_LAPTOP:
                        if (a < c)          nxt = MODE_CLOSING;
                        else if (a >= l + h) nxt = MODE_FLAT;
                        else                nxt = MODE_LAPTOP;
                    MODE_FLAT:
                        if (a < c)          nxt = MODE_CLOSING;
                        else if (a < l - h) nxt = MODE_LAPTOP;
                        else if (a >= f + h) nxt = MODE_TENT;
                        else                nxt = MODE_FLAT;
                    MODE_TENT:
                        if (a < c)          nxt = MODE_CLOSING;
                        else if (a < f - h) nxt = MODE_FLAT;
                        else if (a >= t + h) nxt = MODE_TABLET;
                        else                nxt = MODE_TENT;
                    default:
                        nxt = (a < t - h) ? MODE_TENT : MODE_TABLET;
                endcase
            end
            // A low raw angle while tent is already leaning to tablet keeps counting tablet.
            if (mode_now == MODE_TENT && pend_valid && pend_mode == MODE_TABLET &&
                angle < MIRROR_BELOW && pend_count != 0)
                nxt = MODE_TABLET;

            if (nxt == mode_now)
                drop_candidate();
            else if (!(int'(nxt) == int'(mode_now) + 1 || int'(nxt) + 1 == int'(mode_now)))
                drop_candidate();
            else if (!pend_valid || pend_mode != nxt)
            begin
                pend_valid = 1'b1;
                pend_mode  = nxt;
                pend_count = 4'd1;
            end
            else
            begin
                if (pend_count < COUNT_MAX)
                    pend_count++;
                if (pend_count >= thresholds.stability_samples)
                begin
                    mode_now = nxt;
                    drop_candidate();
                end
            end
        end
        res.device_mode = mode_now;
        res.tablet_like = (mode_now == MODE_TENT || mode_now == MODE_TABLET);
        return res;
    endfunction

    task automatic offer_sample(input int ang, input logic [ORIENT_W-1:0] ori,
                                input bit fixed, input result_t fixed_res);
        int      gap;
        result_t guess;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ori, ang[ANGLE_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        guess = track_mode(ang[ANGLE_W-1:0], ori);
        modes_due.push_back(fixed ? fixed_res : guess);
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (modes_due.size() == 0)
            begin
                $error("unexpected result: m_tdata %h with no sample pending", m_tdata);
                mismatches++;
            end
            else
            begin
                want = modes_due.pop_front();
                if (m_tdata[2:0] !== want.device_mode)
                begin
                    $error("device_mode: expected %0d, got %0d", want.device_mode, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[3] !== want.tablet_like)
                begin
                    $error("tablet_like: expected %0d, got %0d", want.tablet_like, m_tdata[3]);
                    mismatches++;
                end
                if (m_tdata[4] !== want.frozen)
                begin
                    $error("frozen: expected %0d, got %0d", want.frozen, m_tdata[4]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hinge_mode_detector regression: fail");
            $finish;
        end
    end

    initial
    begin
        int                  phase;
        int                  i;
        int                  n;
        int                  k;
        int                  run;
        int                  items;
        int                  center;
        int                  ang;
        int                  c;
        int                  l;
        int                  f;
        int                  t;
        logic [ORIENT_W-1:0] ori;
        logic [CDATA_W-1:0]  plan [7];
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase <= 6; phase++)
        begin
            gaps_on = (phase != 6);
            if (phase == 0)
            begin
                for (i = 0; i < 25; i++)
                    offer_sample(probes[i].angle, probes[i].ori, probes[i].fixed,
                                 probes[i].want);
            end
            else
            begin
                c = $urandom_range(100, 900);
                l = c + $urandom_range(200, 1100);
                f = l + $urandom_range(200, 900);
                t = f + $urandom_range(200, 900);
                if (t > 3600)
                    t = 3600;
                case (phase)
                    1: begin
                        plan  = '{12'(c), 12'(l), 12'(f), 12'(t), 12'($urandom_range(0, 300)),
                                  12'($urandom_range(1, 6)), 12'($urandom_range(0, 8))};
                        items = 70;
                    end
                    2: begin
                        plan  = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0};
                        items = 50;
                    end
                    3: begin
                        plan  = '{12'd3600, 12'd3600, 12'd3600, 12'd3600, 12'd900, 12'd15,
                                  12'd15};
                        items = 60;
                    end
                    4: begin
                        // Limits out of order and a stability count of zero.
                        plan  = '{12'($urandom_range(0, 3600)), 12'($urandom_range(0, 3600)),
                                  12'($urandom_range(0, 3600)), 12'($urandom_range(0, 3600)),
                                  12'($urandom_range(0, 900)), 12'd0,
                                  12'($urandom_range(0, 15))};
                        items = 60;
                    end
                    5: begin
                        plan  = '{12'(RST_CLOSING_LIMIT), 12'(RST_LAPTOP_LIMIT),
                                  12'(RST_FLAT_LIMIT), 12'(RST_TENT_LIMIT),
                                  12'(RST_HYSTERESIS_BAND), 12'(RST_STABILITY_SAMPLES),
                                  12'(RST_FREEZE_LENGTH)};
                        items = 80;
                    end
                    default: begin
                        plan  = '{12'(c), 12'(l), 12'(f), 12'(t), 12'($urandom_range(0, 200)),
                                  12'($urandom_range(1, 4)), 12'($urandom_range(0, 5))};
                        items = 130;
                    end
                endcase

                for (i = 0; i < 7; i++)
                begin
                    @(negedge clk);
                    cfg_valid <= 1'b1;
                    cfg_index <= reg_slot[i];
                    cfg_data  <= plan[i];
                    @(posedge clk);
                    while (!cfg_ready)
                        @(posedge clk);
                    case (reg_slot[i])
                        CFG_CLOSING_LIMIT:     thresholds.closing_limit     = plan[i];
                        CFG_LAPTOP_LIMIT:      thresholds.laptop_limit      = plan[i];
                        CFG_FLAT_LIMIT:        thresholds.flat_limit        = plan[i];
                        CFG_TENT_LIMIT:        thresholds.tent_limit        = plan[i];
                        CFG_HYSTERESIS_BAND:   thresholds.hysteresis_band   = plan[i][HYST_W-1:0];
                        CFG_STABILITY_SAMPLES: thresholds.stability_samples = plan[i][COUNT_W-1:0];
                        default:               thresholds.freeze_length     = plan[i][COUNT_W-1:0];
                    endcase
                end
                @(negedge clk);
                cfg_valid <= 1'b0;

                // Runs of steady angles with small jitter, so that candidates can mature.
                ori = ORIENT_W'($urandom_range(0, 7));
                n = 0;
                while (n < items)
                begin
                    run = $urandom_range(1, 16);
                    if ($urandom_range(0, 19) == 0)
                        center = -int'($urandom_range(1, 3600));
                    else
                        center = $urandom_range(0, 3600);
                    if ($urandom_range(0, 4) == 0)
                        ori = ORIENT_W'($urandom_range(0, 7));
                    for (k = 0; k < run && n < items; k++)
                    begin
                        ang = center + int'($urandom_range(0, 80)) - 40;
                        if ($urandom_range(0, 15) == 0)
                            ang = int'($urandom_range(0, 7200)) - 3600;
                        if (ang > 3600)
                            ang = 3600;
                        if (ang < -3600)
                            ang = -3600;
                        offer_sample(ang, ori, 1'b0, NO_RESULT);
                        n++;
                    end
                end
            end

            @(negedge clk);
            s_tvalid <= 1'b0;
            while (modes_due.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end

        if (mismatches == 0)
            $display("hinge_mode_detector regression: pass");
        else
            $display("hinge_mode_detector regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
src/hmd_pkg.sv
src/hmd_cfg.sv
src/hmd_propose.sv
src/hmd_tracker.sv
src/hinge_mode_detector.sv
tb/hinge_mode_detector_tb.sv
